[design/cco_pkg.sv]
// Shared constants for the circle/capsule overlap pipeline.
// Fixed format of the segment parameter t; no dependencies.
`default_nettype none

package cco_pkg;

  // Fraction bits of the segment parameter t
  localparam int T_FRAC = 16;

  // One half in t format: the clamp limit and the rounding offset
  localparam logic [T_FRAC-1:0] T_HALF = {1'b1, {(T_FRAC-1){1'b0}}};

endpackage

`default_nettype wire

[design/circle_capsule_overlap.sv]
// Circle against capsule overlap test, fully pipelined.
// Depends on cco_pkg for the t format constants.
`default_nettype none

// One test item enters per clock and gives one hit item. The pipeline is
// COORD_BITS independent and T_FRAC + 8 register stages long (24 at the
// default t format): three stages form the difference, the dot products and
// the squared axis length, one stage clamps t, one restoring divider stage
// per quotient bit of t follows, then the segment offset multiply, the
// rounding and offset difference, the squaring and the final compare. All
// stages move together: a stall on the output while a result is held
// freezes the whole pipe and raises in_stall, so throughput is one item per
// cycle whenever the output side takes items.
module circle_capsule_overlap
  import cco_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         in_valid,
  output logic                        in_stall,
  input  wire signed [COORD_BITS-1:0] circle_x,
  input  wire signed [COORD_BITS-1:0] circle_y,
  input  wire signed [COORD_BITS-1:0] capsule_x,
  input  wire signed [COORD_BITS-1:0] capsule_y,
  input  wire signed [COORD_BITS-1:0] axis_x,
  input  wire signed [COORD_BITS-1:0] axis_y,
  input  wire        [COORD_BITS-2:0] circle_radius,
  input  wire        [COORD_BITS-2:0] capsule_radius,
  output logic                        out_valid,
  input  wire                         out_stall,
  output logic                        hit
);

  localparam int CW = COORD_BITS;      // coordinate
  localparam int DW = CW + 1;          // centre difference
  localparam int PW = 2 * CW + 2;      // dot product
  localparam int QW = 2 * CW;          // squared axis length, remainder
  localparam int MW = CW + T_FRAC;     // offset product
  localparam int EW = CW + 2;          // distance component
  localparam int SW = 2 * EW;          // squared component

  // Divider stage contents
  typedef struct packed {
    logic [QW-1:0]     rem;
    logic [T_FRAC-1:0] quo;
    logic [QW-1:0]     den;
    logic              t_zero;
    logic              t_clamp;
    logic              t_neg;
    logic [CW-1:0]     ax_mag;
    logic              ax_neg;
    logic [CW-1:0]     ay_mag;
    logic              ay_neg;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic [CW-1:0]     ar;
  } div_t;

  logic adv;

  // Whole pipe advances unless a held result is stalled
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // Stage 1: centre difference, radius sum
  logic                 v1;
  logic signed [DW-1:0] s1_dx, s1_dy;
  logic signed [CW-1:0] s1_ax, s1_ay;
  logic [CW-1:0]        s1_ar;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_dx <= DW'(circle_x) - DW'(capsule_x);
      s1_dy <= DW'(circle_y) - DW'(capsule_y);
      s1_ax <= axis_x;
      s1_ay <= axis_y;
      s1_ar <= CW'(circle_radius) + CW'(capsule_radius);
    end
  end

  // Stage 2: products for dot and squared length
  logic                   v2;
  logic signed [2*CW:0]   s2_pxd, s2_pyd;
  logic signed [QW-1:0]   s2_axx, s2_ayy;
  logic signed [DW-1:0]   s2_dx, s2_dy;
  logic signed [CW-1:0]   s2_ax, s2_ay;
  logic [CW-1:0]          s2_ar;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_pxd <= (2*CW+1)'(s1_ax) * (2*CW+1)'(s1_dx);
      s2_pyd <= (2*CW+1)'(s1_ay) * (2*CW+1)'(s1_dy);
      s2_axx <= QW'(s1_ax) * QW'(s1_ax);
      s2_ayy <= QW'(s1_ay) * QW'(s1_ay);
      s2_dx  <= s1_dx;
      s2_dy  <= s1_dy;
      s2_ax  <= s1_ax;
      s2_ay  <= s1_ay;
      s2_ar  <= s1_ar;
    end
  end

  // Stage 3: dot product and squared axis length
  logic                 v3;
  logic signed [PW-1:0] s3_num;
  logic [QW-1:0]        s3_den;
  logic signed [DW-1:0] s3_dx, s3_dy;
  logic signed [CW-1:0] s3_ax, s3_ay;
  logic [CW-1:0]        s3_ar;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_num <= PW'(s2_pxd) + PW'(s2_pyd);
      s3_den <= $unsigned(s2_axx) + $unsigned(s2_ayy);
      s3_dx  <= s2_dx;
      s3_dy  <= s2_dy;
      s3_ax  <= s2_ax;
      s3_ay  <= s2_ay;
      s3_ar  <= s2_ar;
    end
  end

  // Stage 4: clamp decision and divider setup
  logic signed [PW:0]   twice_num;
  logic signed [PW:0]   sden;
  logic [PW-1:0]        num_mag;
  div_t                 div_in;

  always_comb begin
    twice_num      = {s3_num, 1'b0};
    sden           = $signed({3'b000, s3_den});
    num_mag        = s3_num[PW-1] ? $unsigned(-s3_num) : $unsigned(s3_num);
    div_in.rem     = num_mag[QW-1:0];
    div_in.quo     = '0;
    div_in.den     = s3_den;
    div_in.t_zero  = (s3_den == '0);
    div_in.t_clamp = (twice_num <= -sden) || (twice_num >= sden);
    div_in.t_neg   = s3_num[PW-1];
    div_in.ax_mag  = s3_ax[CW-1] ? $unsigned(-s3_ax) : $unsigned(s3_ax);
    div_in.ax_neg  = s3_ax[CW-1];
    div_in.ay_mag  = s3_ay[CW-1] ? $unsigned(-s3_ay) : $unsigned(s3_ay);
    div_in.ay_neg  = s3_ay[CW-1];
    div_in.dx      = s3_dx;
    div_in.dy      = s3_dy;
    div_in.ar      = s3_ar;
  end

  div_t             dv [T_FRAC+1];
  logic [T_FRAC:0]  dvalid;

  always_ff @(posedge clk) begin
    if (rst) begin
      dvalid[0] <= 1'b0;
    end else if (adv) begin
      dvalid[0] <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv[0] <= div_in;
    end
  end

  // Restoring divider, one quotient bit of t per stage
  for (genvar k = 0; k < T_FRAC; k++) begin : g_div
    logic [QW:0] rem2;
    logic [QW:0] diff;
    div_t        step;

    always_comb begin
      rem2 = {dv[k].rem, 1'b0};
      diff = rem2 - {1'b0, dv[k].den};
      step = dv[k];
      if (!diff[QW]) begin
        step.rem = diff[QW-1:0];
        step.quo = {dv[k].quo[T_FRAC-2:0], 1'b1};
      end else begin
        step.rem = rem2[QW-1:0];
        step.quo = {dv[k].quo[T_FRAC-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dvalid[k+1] <= 1'b0;
      end else if (adv) begin
        dvalid[k+1] <= dvalid[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv[k+1] <= step;
      end
    end
  end

  // Offset multiply: |axis| * |t|
  div_t              dq;
  logic [T_FRAC-1:0] t_mag;

  assign dq = dv[T_FRAC];

  always_comb begin
    priority if (dq.t_zero) begin
      t_mag = '0;
    end else if (dq.t_clamp) begin
      t_mag = T_HALF;
    end else begin
      t_mag = dq.quo;
    end
  end

  logic                 vm;
  logic [MW-1:0]        m_px, m_py;
  logic                 m_nx, m_ny;
  logic signed [DW-1:0] m_dx, m_dy;
  logic [CW-1:0]        m_ar;

  always_ff @(posedge clk) begin
    if (rst) begin
      vm <= 1'b0;
    end else if (adv) begin
      vm <= dvalid[T_FRAC];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_px <= MW'(dq.ax_mag) * MW'(t_mag);
      m_py <= MW'(dq.ay_mag) * MW'(t_mag);
      m_nx <= dq.ax_neg ^ dq.t_neg;
      m_ny <= dq.ay_neg ^ dq.t_neg;
      m_dx <= dq.dx;
      m_dy <= dq.dy;
      m_ar <= dq.ar;
    end
  end

  // Round offset to coordinate units, subtract centre difference
  logic [MW-1:0]        rnd_x, rnd_y;
  logic signed [EW-1:0] ox, oy;

  always_comb begin
    rnd_x = m_px + MW'(T_HALF);
    rnd_y = m_py + MW'(T_HALF);
    ox    = $signed(EW'(rnd_x[MW-1:T_FRAC]));
    oy    = $signed(EW'(rnd_y[MW-1:T_FRAC]));
    if (m_nx) begin
      ox = -ox;
    end
    if (m_ny) begin
      oy = -oy;
    end
  end

  logic                 vr;
  logic signed [EW-1:0] r_ex, r_ey;
  logic [CW-1:0]        r_ar;

  always_ff @(posedge clk) begin
    if (rst) begin
      vr <= 1'b0;
    end else if (adv) begin
      vr <= vm;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r_ex <= ox - EW'(m_dx);
      r_ey <= oy - EW'(m_dy);
      r_ar <= m_ar;
    end
  end

  // Squares of distance components and radius sum
  logic                 vq;
  logic signed [SW-1:0] q_sx, q_sy;
  logic [QW-1:0]        q_ar2;

  always_ff @(posedge clk) begin
    if (rst) begin
      vq <= 1'b0;
    end else if (adv) begin
      vq <= vr;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q_sx  <= SW'(r_ex) * SW'(r_ex);
      q_sy  <= SW'(r_ey) * SW'(r_ey);
      q_ar2 <= QW'(r_ar) * QW'(r_ar);
    end
  end

  // Final compare into the output register
  logic [SW:0] dist_sq;

  assign dist_sq = {1'b0, $unsigned(q_sx)} + {1'b0, $unsigned(q_sy)};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vq;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hit <= (dist_sq < (SW+1)'(q_ar2));
    end
  end

endmodule

`default_nettype wire

[verif/testbench.sv]
// Testbench for circle_capsule_overlap: directed corner tests, then random
// circle/capsule pairs checked against a bit-exact predictor in a scoreboard.
// Depends on cco_pkg (t format) and the circle_capsule_overlap RTL.
`timescale 1ns / 1ps

module testbench
  import cco_pkg::*;
;

  localparam int CW            = 16;
  localparam int PIPE_LATENCY  = T_FRAC + 8;
  localparam int RANDOM_TESTS  = 800;
  localparam int HOLD_CYCLES   = 200;
  localparam int STALL_LIMIT   = 3000;

  typedef struct {
    logic signed [CW-1:0] circle_x;
    logic signed [CW-1:0] circle_y;
    logic signed [CW-1:0] capsule_x;
    logic signed [CW-1:0] capsule_y;
    logic signed [CW-1:0] axis_x;
    logic signed [CW-1:0] axis_y;
    logic        [CW-2:0] circle_radius;
    logic        [CW-2:0] capsule_radius;
  } overlap_test_t;

  // Holds predicted hit flags in order and compares arriving results
  class overlap_scoreboard;
    bit pending_hits[$];
    int errors;
    int tests_checked;
    int hits_seen;

    // t / 2^T_FRAC scaled back to coordinate units, ties away from zero
    function longint round_offset(longint v);
      longint half;
      half = longint'(1) << (T_FRAC - 1);
      if (v >= 0) return (v + half) >> T_FRAC;
      return -((-v + half) >> T_FRAC);
    endfunction

    function bit overlap_of(overlap_test_t t);
      longint dx, dy, num, den, t16, mag, ex, ey, dist_sq, rsum, half;
      half = longint'(1) << (T_FRAC - 1);
      dx   = longint'(t.circle_x) - longint'(t.capsule_x);
      dy   = longint'(t.circle_y) - longint'(t.capsule_y);
      num  = longint'(t.axis_x) * dx + longint'(t.axis_y) * dy;
      den  = longint'(t.axis_x) * longint'(t.axis_x)
           + longint'(t.axis_y) * longint'(t.axis_y);
      t16  = 0;
      // zero axis leaves t at 0: plain circle against circle
      if (den != 0) begin
        if (2 * num <= -den) t16 = -half;
        else if (2 * num >= den) t16 = half;
        else begin
          mag = (num < 0) ? -num : num;
          t16 = (mag << T_FRAC) / den;
          if (num < 0) t16 = -t16;
        end
      end
      ex      = round_offset(longint'(t.axis_x) * t16) - dx;
      ey      = round_offset(longint'(t.axis_y) * t16) - dy;
      dist_sq = ex * ex + ey * ey;
      rsum    = longint'(t.circle_radius) + longint'(t.capsule_radius);
      // touching counts as no overlap
      return dist_sq < rsum * rsum;
    endfunction

    function void note_test(overlap_test_t t);
      pending_hits.push_back(overlap_of(t));
    endfunction

    function void check_hit(logic got);
      bit want;
      if (pending_hits.size() == 0) begin
        $display("%0t: ERROR hit item with none expected, actual %b", $time, got);
        errors++;
        return;
      end
      want = pending_hits.pop_front();
      tests_checked++;
      if (got === 1'b1) hits_seen++;
      if (got !== want) begin
        $display("%0t: ERROR hit mismatch, expected %b actual %b", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic          clk;
  logic          rst;
  logic          in_valid;
  logic          in_stall;
  logic          out_valid;
  logic          out_stall;
  logic          hit;
  overlap_test_t drv;

  overlap_scoreboard sb = new;

  bit sender_idles;
  bit want_backpressure;
  bit backpressure_done;
  int quiet_cycles;

  circle_capsule_overlap #(.COORD_BITS(CW)) dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .circle_x       (drv.circle_x),
    .circle_y       (drv.circle_y),
    .capsule_x      (drv.capsule_x),
    .capsule_y      (drv.capsule_y),
    .axis_x         (drv.axis_x),
    .axis_y         (drv.axis_y),
    .circle_radius  (drv.circle_radius),
    .capsule_radius (drv.capsule_radius),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .hit            (hit)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Record accepted tests and check accepted results
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) sb.note_test(drv);
    if (!rst && out_valid && !out_stall) sb.check_hit(hit);
  end

  // Watchdog on cycles where neither side moves an item
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("circle_capsule_overlap verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function overlap_test_t make_test(int cx, int cy, int px, int py,
                                    int ax, int ay, int r1, int r2);
    overlap_test_t t;
    t.circle_x       = CW'(cx);
    t.circle_y       = CW'(cy);
    t.capsule_x      = CW'(px);
    t.capsule_y      = CW'(py);
    t.axis_x         = CW'(ax);
    t.axis_y         = CW'(ay);
    t.circle_radius  = (CW-1)'(r1);
    t.capsule_radius = (CW-1)'(r2);
    return t;
  endfunction

  function int around(int center, int span);
    return center + int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // Mostly local pairs so hits and misses both show up often
  function overlap_test_t random_test();
    overlap_test_t t;
    int kind, px, py, ax, ay;
    kind = $urandom_range(0, 99);
    if (kind < 35) begin
      t = make_test($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom);
    end else if (kind < 88) begin
      px = around(0, 20000);
      py = around(0, 20000);
      ax = around(0, 3000);
      ay = around(0, 3000);
      // zero axis or an axis along one coordinate
      if (kind >= 75) begin
        case ($urandom_range(0, 2))
          0: begin ax = 0; ay = 0; end
          1: ax = 0;
          default: ay = 0;
        endcase
      end
      t = make_test(around(px, 2000), around(py, 2000), px, py, ax, ay,
                    $urandom_range(0, 1500), $urandom_range(0, 1500));
    end else begin
      t = make_test(around(0, 8), around(0, 8), around(0, 8), around(0, 8),
                    around(0, 8), around(0, 8), $urandom_range(0, 8),
                    $urandom_range(0, 8));
    end
    return t;
  endfunction

  // Mostly back to back, some short gaps, a few long ones
  function int pick_gap();
    int roll;
    if (!sender_idles) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // Called just after the previous item's accepting edge
  task automatic drive_test(overlap_test_t t);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_valid = 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    drv      = t;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  // Receiver: random stall pattern, plus one long hold-off on request
  initial begin
    int run;
    out_stall = 1'b0;
    wait (!rst);
    forever begin
      if (want_backpressure && !backpressure_done) begin
        @(negedge clk);
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall = 1'b0;
        backpressure_done = 1'b1;
      end else begin
        run = $urandom_range(0, 99);
        @(negedge clk);
        if (run < 55) begin
          out_stall = 1'b0;
          repeat ($urandom_range(0, 8)) @(negedge clk);
        end else if (run < 62) begin
          out_stall = 1'b0;
          repeat (60) @(negedge clk);
        end else if (run < 93) begin
          out_stall = 1'b1;
          repeat ($urandom_range(0, 3)) @(negedge clk);
        end else begin
          out_stall = 1'b1;
          repeat ($urandom_range(10, 40)) @(negedge clk);
        end
      end
    end
  end

  // Stimulus and end of run
  initial begin
    overlap_test_t corner_tests[$];
    int seg;
    rst               = 1'b1;
    in_valid          = 1'b0;
    drv               = make_test(0, 0, 0, 0, 0, 0, 0, 0);
    sender_idles      = 1'b1;
    want_backpressure = 1'b0;
    backpressure_done = 1'b0;
    quiet_cycles      = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // zero radii on a single point, then a unit radius
    corner_tests.push_back(make_test(0, 0, 0, 0, 0, 0, 0, 0));
    corner_tests.push_back(make_test(0, 0, 0, 0, 0, 0, 1, 0));
    // zero axis: touching circles miss, one more unit hits
    corner_tests.push_back(make_test(5, 0, 0, 0, 0, 0, 2, 3));
    corner_tests.push_back(make_test(5, 0, 0, 0, 0, 0, 2, 4));
    // t clamped at the negative end, touching then overlapping
    corner_tests.push_back(make_test(-500, 0, 0, 0, 100, 0, 200, 250));
    corner_tests.push_back(make_test(-500, 0, 0, 0, 100, 0, 200, 251));
    // t clamped at the positive end, then at the negative end with the axis negated
    corner_tests.push_back(make_test(0, 500, 0, 0, 0, 100, 451, 0));
    corner_tests.push_back(make_test(0, 500, 0, 0, 0, -100, 200, 250));
    // interior t: nearest point (20,0), distance 30, then mirrored
    corner_tests.push_back(make_test(20, 30, 0, 0, 100, 0, 10, 20));
    corner_tests.push_back(make_test(20, 30, 0, 0, 100, 0, 10, 21));
    corner_tests.push_back(make_test(-20, -30, 0, 0, -100, 0, 10, 21));
    // projection exactly on the segment ends
    corner_tests.push_back(make_test(1, 0, 0, 0, 2, 0, 0, 1));
    corner_tests.push_back(make_test(-1, 0, 0, 0, 2, 0, 1, 0));
    // coordinate and radius extremes
    corner_tests.push_back(make_test(32767, 32767, -32768, -32768, -32768, -32768,
                                     32767, 32767));
    corner_tests.push_back(make_test(-32768, -32768, 32767, 32767, 32767, 32767,
                                     32767, 32767));
    corner_tests.push_back(make_test(-32768, 32767, 32767, -32768, -32768, 0, 0, 0));
    corner_tests.push_back(make_test(32767, -32768, -32768, 32767, 0, 32767,
                                     32767, 0));
    corner_tests.push_back(make_test(32767, 32767, -32768, -32768, 0, 0, 32767, 32767));
    corner_tests.push_back(make_test(-32768, -32768, -32768, -32768, -32768, -32768,
                                     0, 0));
    corner_tests.push_back(make_test(7, -3, 0, 0, 3, 1, 2, 2));
    foreach (corner_tests[i]) drive_test(corner_tests[i]);

    // random part in segments: idle, back to back, and one held-off burst
    for (int i = 0; i < RANDOM_TESTS; i++) begin
      seg          = i / 100;
      sender_idles = !(seg % 4 == 1 || seg == 3);
      if (seg == 3) want_backpressure = 1'b1;
      drive_test(random_test());
    end
    @(negedge clk);
    in_valid = 1'b0;

    while (sb.pending_hits.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 16) @(posedge clk);

    $display("Checked %0d overlap tests (%0d hits): zero axis, touching, clamped ends,",
             sb.tests_checked, sb.hits_seen);
    $display("field extremes and random pairs under idle gaps and output hold-off.");
    if (sb.errors == 0 && sb.pending_hits.size() == 0) begin
      $display("circle_capsule_overlap verification clean");
    end else begin
      $display("circle_capsule_overlap verification failed");
    end
    $finish;
  end

endmodule
